/* rtl/spwf_pkg.sv */
// ---------------------------------------------------------------------------
// spwf_pkg - shared types and constants of the sky-plane point window filter
// Register indexes, verdict codes, test mask bits and the CORDIC arctangent
// table used by the filter pipeline and its checker.
// ---------------------------------------------------------------------------
package spwf_pkg;

   localparam int AXIS_COMP_BITS = 18;
   localparam int AXIS_BITS      = 3 * AXIS_COMP_BITS;
   localparam int CSR_INDEX_BITS = 3;
   localparam int RADIUS_BITS    = 31;
   localparam int MASK_BITS      = 3;
   localparam int VERDICT_BITS   = 3;
   localparam int NORM_BIT       = 51;
   localparam int TABLE_LEN      = 24;
   localparam int ZBITS          = 32;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [VERDICT_BITS-1:0]   verdict_type;

   localparam csr_index_type REG_VIEW_AXIS   = 3'd0;
   localparam csr_index_type REG_EAST_AXIS   = 3'd1;
   localparam csr_index_type REG_NORTH_AXIS  = 3'd2;
   localparam csr_index_type REG_TARGET      = 3'd3;
   localparam csr_index_type REG_TOLERANCE   = 3'd4;
   localparam csr_index_type REG_MIN_RADIUS  = 3'd5;
   localparam csr_index_type REG_TEST_MASK   = 3'd6;

   localparam verdict_type VERDICT_KEPT     = 3'd0;
   localparam verdict_type VERDICT_BEHIND   = 3'd1;
   localparam verdict_type VERDICT_TOO_NEAR = 3'd2;
   localparam verdict_type VERDICT_ON_AXIS  = 3'd3;
   localparam verdict_type VERDICT_OUTSIDE  = 3'd4;

   localparam int MASK_VISIBILITY = 0;
   localparam int MASK_RADIUS     = 1;
   localparam int MASK_WINDOW     = 2;

   localparam logic [MASK_BITS-1:0] MASK_RESET = 3'b111;

   // atan(2^-i) in units of 2^-32 of a full circle
   function automatic logic [ZBITS-1:0] atan_unit(input logic [4:0] idx);
      logic [ZBITS-1:0] val;
      case (idx)
         5'd0:    val = 32'h20000000;
         5'd1:    val = 32'h12E4051E;
         5'd2:    val = 32'h09FB385B;
         5'd3:    val = 32'h051111D4;
         5'd4:    val = 32'h028B0D43;
         5'd5:    val = 32'h0145D7E1;
         5'd6:    val = 32'h00A2F61E;
         5'd7:    val = 32'h00517C55;
         5'd8:    val = 32'h0028BE53;
         5'd9:    val = 32'h00145F2F;
         5'd10:   val = 32'h000A2F98;
         5'd11:   val = 32'h000517CC;
         5'd12:   val = 32'h00028BE6;
         5'd13:   val = 32'h000145F3;
         5'd14:   val = 32'h0000A2FA;
         5'd15:   val = 32'h0000517D;
         5'd16:   val = 32'h000028BE;
         5'd17:   val = 32'h0000145F;
         5'd18:   val = 32'h00000A30;
         5'd19:   val = 32'h00000518;
         5'd20:   val = 32'h0000028C;
         5'd21:   val = 32'h00000146;
         5'd22:   val = 32'h000000A3;
         5'd23:   val = 32'h00000051;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

/* rtl/sky_plane_point_window_filter.sv */
// ---------------------------------------------------------------------------
// sky_plane_point_window_filter - streaming 3-D point visibility/radius/angle
// Projects each point on the observer direction and the sky plane, takes its
// position angle with a pipelined CORDIC and returns a verdict per point.
// ---------------------------------------------------------------------------
// Usage:
//  - Points arrive on the req_ channel (valid/stall); one transfer carries
//    px, py, pz and the end-of-cloud marker.
//  - Every point gives exactly one rsp_ transfer: the echoed point, a
//    verdict (kept, behind, too near, on axis, outside window), its position
//    angle and the echoed marker, in arrival order.
//  - Throughput: one point per cycle while rsp_stall holds no waiting result.
//    The CORDIC stage chain, one stage per register, has CORDIC_STAGES
//    stages, at most 24.
//  - The pipeline advances as a whole while the output register is empty
//    or being taken; when rsp_stall holds a waiting result, req_stall rises
//    and every stage holds its contents, so nothing is lost or repeated.
//  - Reset (synchronous, active high) empties the pipeline and loads the
//    registers: axes, target, tolerance and radius zero, test mask 3'b111.
//  - Write csr_ registers only while the pipeline is empty.
// ---------------------------------------------------------------------------
module sky_plane_point_window_filter #(
   parameter int COORD_BITS    = 32,
   parameter int ANGLE_BITS    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [COORD_BITS-1:0]           req_px,
   input  logic signed [COORD_BITS-1:0]           req_py,
   input  logic signed [COORD_BITS-1:0]           req_pz,
   input  logic                                   req_end_of_cloud,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [COORD_BITS-1:0]           rsp_out_x,
   output logic signed [COORD_BITS-1:0]           rsp_out_y,
   output logic signed [COORD_BITS-1:0]           rsp_out_z,
   output logic [spwf_pkg::VERDICT_BITS-1:0]      rsp_verdict,
   output logic [ANGLE_BITS-1:0]                  rsp_point_angle,
   output logic                                   rsp_end_out,
   input  logic                                   csr_we,
   input  logic [spwf_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [spwf_pkg::AXIS_BITS-1:0]         csr_wdata
);

   localparam int CB  = COORD_BITS;
   localparam int AB  = ANGLE_BITS;
   localparam int CMP = spwf_pkg::AXIS_COMP_BITS;
   localparam int PW  = CB + CMP;          // one product
   localparam int SW  = PW + 2;            // sum of three products
   localparam int EW  = SW - 16;           // rounded sky coordinate
   localparam int XW  = (EW > 32) ? EW : 32;
   localparam int RB  = spwf_pkg::RADIUS_BITS;
   localparam int CW  = 56;                // CORDIC datapath
   localparam int ZB  = spwf_pkg::ZBITS;
   localparam int NST = (CORDIC_STAGES > spwf_pkg::TABLE_LEN) ?
                        spwf_pkg::TABLE_LEN : CORDIC_STAGES;
   localparam logic [AB-1:0] HALF_ANG = AB'(1 << (AB - 1));
   localparam logic [ZB-1:0] Z_ROUND  = ZB'(1) << (31 - AB);
   localparam logic [ZB-1:0] Z_HALF   = ZB'(1) << 31;

   typedef struct packed {
      logic signed [CB-1:0] x;
      logic signed [CB-1:0] y;
      logic signed [CB-1:0] z;
      logic                 eoc;
      logic                 vis;
      logic                 far;
      logic                 on_axis;
   } item_type;

   // configuration registers
   logic [spwf_pkg::AXIS_BITS-1:0] view_ff, east_ff, north_ff;
   logic [AB-1:0]                  target_ff, tol_ff;
   logic [RB-1:0]                  min_rad_ff;
   logic [spwf_pkg::MASK_BITS-1:0] mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         view_ff    <= '0;
         east_ff    <= '0;
         north_ff   <= '0;
         target_ff  <= '0;
         tol_ff     <= '0;
         min_rad_ff <= '0;
         mask_ff    <= spwf_pkg::MASK_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            spwf_pkg::REG_VIEW_AXIS:  view_ff    <= csr_wdata;
            spwf_pkg::REG_EAST_AXIS:  east_ff    <= csr_wdata;
            spwf_pkg::REG_NORTH_AXIS: north_ff   <= csr_wdata;
            spwf_pkg::REG_TARGET:     target_ff  <= csr_wdata[AB-1:0];
            spwf_pkg::REG_TOLERANCE:  tol_ff     <= csr_wdata[AB-1:0];
            spwf_pkg::REG_MIN_RADIUS: min_rad_ff <= csr_wdata[RB-1:0];
            spwf_pkg::REG_TEST_MASK:  mask_ff    <= csr_wdata[spwf_pkg::MASK_BITS-1:0];
            default: ;
         endcase
      end
   end

   // global advance: the whole pipeline moves when the output slot frees
   logic rsp_valid_ff;
   logic adv;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // ---- stage 1: capture the point ----
   logic     s1_vld_ff;
   item_type s1_item_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_item_ff.x       <= req_px;
         s1_item_ff.y       <= req_py;
         s1_item_ff.z       <= req_pz;
         s1_item_ff.eoc     <= req_end_of_cloud;
         s1_item_ff.vis     <= 1'b0;
         s1_item_ff.far     <= 1'b0;
         s1_item_ff.on_axis <= 1'b0;
      end
   end

   // ---- stage 2: nine coordinate by axis-component products ----
   logic signed [PW-1:0] s2_prod_in [0:2][0:2];
   logic signed [PW-1:0] s2_prod_ff [0:2][0:2];
   logic                 s2_vld_ff;
   item_type             s2_item_ff;

   always_comb begin
      logic [spwf_pkg::AXIS_BITS-1:0] ax;
      logic signed [CB-1:0]           pc;
      logic signed [CMP-1:0]          bc;
      for (int a = 0; a < 3; a++) begin
         for (int k = 0; k < 3; k++) begin
            ax = (a == 0) ? view_ff : ((a == 1) ? east_ff : north_ff);
            pc = (k == 0) ? s1_item_ff.x : ((k == 1) ? s1_item_ff.y : s1_item_ff.z);
            bc = $signed(ax[k*CMP +: CMP]);
            s2_prod_in[a][k] = PW'(pc) * PW'(bc);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_prod_ff <= s2_prod_in;
         s2_item_ff <= s1_item_ff;
      end
   end

   // ---- stage 3: exact dot products ----
   logic signed [SW-1:0] s3_sum_ff [0:2];
   logic                 s3_vld_ff;
   item_type             s3_item_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            s3_sum_ff[a] <= SW'(s2_prod_ff[a][0]) + SW'(s2_prod_ff[a][1])
                            + SW'(s2_prod_ff[a][2]);
         end
         s3_item_ff <= s2_item_ff;
      end
   end

   // ---- stage 4: visibility sign, round sky coordinates half up ----
   logic signed [EW-1:0] s4_east_ff, s4_north_ff;
   logic                 s4_vld_ff;
   item_type             s4_item_ff;
   item_type             s4_item_in;
   logic signed [SW-1:0] s4_east_rnd, s4_north_rnd;
   always_comb begin
      s4_east_rnd    = s3_sum_ff[1] + (SW'(1) <<< 15);
      s4_north_rnd   = s3_sum_ff[2] + (SW'(1) <<< 15);
      s4_item_in     = s3_item_ff;
      s4_item_in.vis = !s3_sum_ff[0][SW-1] && (s3_sum_ff[0] != '0);
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s4_east_ff  <= EW'(s4_east_rnd >>> 16);
         s4_north_ff <= EW'(s4_north_rnd >>> 16);
         s4_item_ff  <= s4_item_in;
      end
   end

   // ---- stage 5: magnitudes and on-axis flag ----
   logic signed [EW-1:0] s5_east_ff, s5_north_ff;
   logic [XW-1:0]        s5_mag_e_ff, s5_mag_n_ff;
   logic                 s5_vld_ff;
   item_type             s5_item_ff;
   item_type             s5_item_in;
   always_comb begin
      s5_item_in         = s4_item_ff;
      s5_item_in.on_axis = (s4_east_ff == '0) && (s4_north_ff == '0);
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (adv) begin
         s5_vld_ff <= s4_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s5_east_ff  <= s4_east_ff;
         s5_north_ff <= s4_north_ff;
         s5_mag_e_ff <= XW'(s4_east_ff[EW-1] ? $unsigned(-s4_east_ff)
                                             : $unsigned(s4_east_ff));
         s5_mag_n_ff <= XW'(s4_north_ff[EW-1] ? $unsigned(-s4_north_ff)
                                              : $unsigned(s4_north_ff));
         s5_item_ff  <= s5_item_in;
      end
   end

   // ---- stage 6: squares and normalizing shift count ----
   logic [2*RB-1:0]      s6_sq_e_ff, s6_sq_n_ff, s6_sq_r_ff;
   logic                 s6_big_ff;
   logic [5:0]           s6_shift_ff;
   logic signed [EW-1:0] s6_east_ff, s6_north_ff;
   logic                 s6_vld_ff;
   item_type             s6_item_ff;
   logic [5:0]           s6_shift_in;
   always_comb begin
      logic [XW-1:0] m;
      int            msb;
      m   = s5_mag_e_ff | s5_mag_n_ff;
      msb = 0;
      for (int i = 0; i < XW; i++) begin
         if (m[i]) begin
            msb = i;
         end
      end
      s6_shift_in = (msb >= spwf_pkg::NORM_BIT) ? 6'd0 : 6'(spwf_pkg::NORM_BIT - msb);
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else if (adv) begin
         s6_vld_ff <= s5_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s6_sq_e_ff  <= (2*RB)'(s5_mag_e_ff[RB-1:0]) * (2*RB)'(s5_mag_e_ff[RB-1:0]);
         s6_sq_n_ff  <= (2*RB)'(s5_mag_n_ff[RB-1:0]) * (2*RB)'(s5_mag_n_ff[RB-1:0]);
         s6_sq_r_ff  <= (2*RB)'(min_rad_ff) * (2*RB)'(min_rad_ff);
         s6_big_ff   <= (s5_mag_e_ff[XW-1:RB] != '0) || (s5_mag_n_ff[XW-1:RB] != '0);
         s6_shift_ff <= s6_shift_in;
         s6_east_ff  <= s5_east_ff;
         s6_north_ff <= s5_north_ff;
         s6_item_ff  <= s5_item_ff;
      end
   end

   // ---- stage 7: radius compare, normalize the vector ----
   logic signed [CW-1:0] s7_x_ff, s7_y_ff;
   logic                 s7_vld_ff;
   item_type             s7_item_ff;
   item_type             s7_item_in;
   always_comb begin
      s7_item_in     = s6_item_ff;
      s7_item_in.far = s6_big_ff ||
         (((2*RB+1)'(s6_sq_e_ff) + (2*RB+1)'(s6_sq_n_ff)) >= (2*RB+1)'(s6_sq_r_ff));
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else if (adv) begin
         s7_vld_ff <= s6_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s7_x_ff    <= CW'(s6_north_ff) <<< s6_shift_ff;
         s7_y_ff    <= CW'(s6_east_ff) <<< s6_shift_ff;
         s7_item_ff <= s7_item_in;
      end
   end

   // ---- stage 8 and CORDIC chain: turn left half plane, then vector ----
   logic signed [CW-1:0] cx_ff [0:NST];
   logic signed [CW-1:0] cy_ff [0:NST];
   logic [ZB-1:0]        cz_ff [0:NST];
   item_type             ci_ff [0:NST];
   logic                 cv_ff [0:NST];

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else if (adv) begin
         cv_ff[0] <= s7_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         cx_ff[0] <= s7_x_ff[CW-1] ? -s7_x_ff : s7_x_ff;
         cy_ff[0] <= s7_x_ff[CW-1] ? -s7_y_ff : s7_y_ff;
         cz_ff[0] <= s7_x_ff[CW-1] ? Z_HALF : '0;
         ci_ff[0] <= s7_item_ff;
      end
   end

   for (genvar i = 0; i < NST; i++) begin : g_cordic
      logic signed [CW-1:0] dx, dy;
      logic                 rot_pos;
      assign dx      = cy_ff[i] >>> i;
      assign dy      = cx_ff[i] >>> i;
      assign rot_pos = !cy_ff[i][CW-1] && (cy_ff[i] != '0);

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i+1] <= 1'b0;
         end else if (adv) begin
            cv_ff[i+1] <= cv_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            if (rot_pos) begin
               cx_ff[i+1] <= cx_ff[i] + dx;
               cy_ff[i+1] <= cy_ff[i] - dy;
               cz_ff[i+1] <= cz_ff[i] + spwf_pkg::atan_unit(5'(i));
            end else begin
               cx_ff[i+1] <= cx_ff[i] - dx;
               cy_ff[i+1] <= cy_ff[i] + dy;
               cz_ff[i+1] <= cz_ff[i] - spwf_pkg::atan_unit(5'(i));
            end
            ci_ff[i+1] <= ci_ff[i];
         end
      end
   end

   // ---- final stage: round angle, circular distance to target ----
   logic [AB-1:0] fin_angle_ff;
   logic          fin_in_win_ff;
   logic          fin_vld_ff;
   item_type      fin_item_ff;
   logic [AB-1:0] fin_angle_in;
   logic          fin_in_win_in;
   always_comb begin
      logic [ZB-1:0] zr;
      logic [AB-1:0] d;
      zr           = cz_ff[NST] + Z_ROUND;
      fin_angle_in = ci_ff[NST].on_axis ? '0 : zr[ZB-1 -: AB];
      d            = fin_angle_in - target_ff;
      if (d > HALF_ANG) begin
         d = -d;
      end
      fin_in_win_in = (d <= tol_ff);
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         fin_vld_ff <= 1'b0;
      end else if (adv) begin
         fin_vld_ff <= cv_ff[NST];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         fin_angle_ff  <= fin_angle_in;
         fin_in_win_ff <= fin_in_win_in;
         fin_item_ff   <= ci_ff[NST];
      end
   end

   // ---- output register: verdict by test priority ----
   spwf_pkg::verdict_type verdict_in;
   always_comb begin
      if (mask_ff[spwf_pkg::MASK_VISIBILITY] && !fin_item_ff.vis) begin
         verdict_in = spwf_pkg::VERDICT_BEHIND;
      end else if (mask_ff[spwf_pkg::MASK_RADIUS] && !fin_item_ff.far) begin
         verdict_in = spwf_pkg::VERDICT_TOO_NEAR;
      end else if (mask_ff[spwf_pkg::MASK_WINDOW] && fin_item_ff.on_axis) begin
         verdict_in = spwf_pkg::VERDICT_ON_AXIS;
      end else if (mask_ff[spwf_pkg::MASK_WINDOW] && !fin_in_win_ff) begin
         verdict_in = spwf_pkg::VERDICT_OUTSIDE;
      end else begin
         verdict_in = spwf_pkg::VERDICT_KEPT;
      end
   end

   logic signed [CB-1:0]  rsp_x_ff, rsp_y_ff, rsp_z_ff;
   spwf_pkg::verdict_type rsp_verdict_ff;
   logic [AB-1:0]         rsp_angle_ff;
   logic                  rsp_end_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= fin_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_x_ff       <= fin_item_ff.x;
         rsp_y_ff       <= fin_item_ff.y;
         rsp_z_ff       <= fin_item_ff.z;
         rsp_verdict_ff <= verdict_in;
         rsp_angle_ff   <= fin_angle_ff;
         rsp_end_ff     <= fin_item_ff.eoc;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_x       = rsp_x_ff;
   assign rsp_out_y       = rsp_y_ff;
   assign rsp_out_z       = rsp_z_ff;
   assign rsp_verdict     = rsp_verdict_ff;
   assign rsp_point_angle = rsp_angle_ff;
   assign rsp_end_out     = rsp_end_ff;

endmodule

/* rtl/spwf_chk.sv */
// ---------------------------------------------------------------------------
// spwf_chk - port-level checks of the sky-plane point window filter
// Watches the handshakes and result fields over time; bound to the top level.
// ---------------------------------------------------------------------------
module spwf_chk #(
   parameter int COORD_BITS = 32,
   parameter int ANGLE_BITS = 16
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [COORD_BITS-1:0]      rsp_out_x,
   input logic [spwf_pkg::VERDICT_BITS-1:0] rsp_verdict,
   input logic [ANGLE_BITS-1:0]             rsp_point_angle
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_verdict))
      else $error("stalled result changed");

   a_verdict_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_verdict == spwf_pkg::VERDICT_KEPT ||
                     rsp_verdict == spwf_pkg::VERDICT_BEHIND ||
                     rsp_verdict == spwf_pkg::VERDICT_TOO_NEAR ||
                     rsp_verdict == spwf_pkg::VERDICT_ON_AXIS ||
                     rsp_verdict == spwf_pkg::VERDICT_OUTSIDE))
      else $error("verdict code out of range");

   a_on_axis_angle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict == spwf_pkg::VERDICT_ON_AXIS |-> rsp_point_angle == '0)
      else $error("on-axis point with nonzero angle");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a blocked result");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind sky_plane_point_window_filter spwf_chk #(
   .COORD_BITS(COORD_BITS),
   .ANGLE_BITS(ANGLE_BITS)
) u_spwf_chk (.*);

/* verif/tb_sky_plane_point_window_filter.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_sky_plane_point_window_filter - self-checking bench for the point filter
// Streams directed and random points through the filter under several
// register settings and random idling on both channels. An in-bench
// predictor computes the verdict and the position angle of every accepted
// point, and each returned point is checked against it in order.
// ---------------------------------------------------------------------------

typedef struct {
   logic signed [31:0]    x;
   logic signed [31:0]    y;
   logic signed [31:0]    z;
   spwf_pkg::verdict_type verdict;
   logic [15:0]           angle;
   logic                  marker;
} point_verdict_type;

class verdict_board;
   point_verdict_type pending_q[$];
   int                errors;
   logic [spwf_pkg::AXIS_BITS-1:0]   view_axis, east_axis, north_axis;
   logic [15:0]                      target, tolerance;
   logic [spwf_pkg::RADIUS_BITS-1:0] min_radius;
   logic [spwf_pkg::MASK_BITS-1:0]   test_mask;

   // arctangent steps, units of 2^-32 circle
   logic [31:0] atan_steps [16] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};

   function new();
      errors = 0;
      view_axis = '0;
      east_axis = '0;
      north_axis = '0;
      target = '0;
      tolerance = '0;
      min_radius = '0;
      test_mask = spwf_pkg::MASK_RESET;
   endfunction

   function void write_reg(spwf_pkg::csr_index_type idx,
                           logic [spwf_pkg::AXIS_BITS-1:0] data);
      case (idx)
         spwf_pkg::REG_VIEW_AXIS:  view_axis = data;
         spwf_pkg::REG_EAST_AXIS:  east_axis = data;
         spwf_pkg::REG_NORTH_AXIS: north_axis = data;
         spwf_pkg::REG_TARGET:     target = data[15:0];
         spwf_pkg::REG_TOLERANCE:  tolerance = data[15:0];
         spwf_pkg::REG_MIN_RADIUS: min_radius = data[spwf_pkg::RADIUS_BITS-1:0];
         spwf_pkg::REG_TEST_MASK:  test_mask = data[spwf_pkg::MASK_BITS-1:0];
         default: ;
      endcase
   endfunction

   // exact dot product of the point with one packed Q1.16 axis
   function longint dot_axis(logic [spwf_pkg::AXIS_BITS-1:0] axis, longint x, longint y,
                             longint z);
      longint bx, by, bz;
      bx = longint'($signed(axis[17:0]));
      by = longint'($signed(axis[35:18]));
      bz = longint'($signed(axis[53:36]));
      return x * bx + y * by + z * bz;
   endfunction

   function logic [15:0] position_angle(longint east, longint north);
      longint xv, yv, dx, dy;
      longint lim;
      logic [31:0] acc;
      logic [32:0] rounded;
      xv = north;
      yv = east;
      lim = longint'(1) << 51;
      acc = '0;
      if (xv == 0 && yv == 0) return '0;
      while ((xv < 0 ? -xv : xv) < lim && (yv < 0 ? -yv : yv) < lim) begin
         xv = xv * 2;
         yv = yv * 2;
      end
      // fold the left half-plane over by half a turn
      if (xv < 0) begin
         xv = -xv;
         yv = -yv;
         acc = 32'h80000000;
      end
      for (int i = 0; i < 16; i++) begin
         dx = yv >>> i;
         dy = xv >>> i;
         if (yv > 0) begin
            xv = xv + dx;
            yv = yv - dy;
            acc = acc + atan_steps[i];
         end else begin
            xv = xv - dx;
            yv = yv + dy;
            acc = acc - atan_steps[i];
         end
      end
      rounded = {1'b0, acc} + 33'h8000;
      return rounded[31:16];
   endfunction

   function void note_point(logic signed [31:0] px, py, pz, logic marker);
      point_verdict_type exp_pt;
      longint xv, yv, zv, seen, east, north;
      longint unsigned ae, an, rmin;
      logic [15:0] diff;
      logic far_enough, in_window;
      xv = longint'(px);
      yv = longint'(py);
      zv = longint'(pz);
      seen = dot_axis(view_axis, xv, yv, zv);
      east = (dot_axis(east_axis, xv, yv, zv) + 32768) >>> 16;
      north = (dot_axis(north_axis, xv, yv, zv) + 32768) >>> 16;
      ae = east < 0 ? -east : east;
      an = north < 0 ? -north : north;
      rmin = longint'(min_radius);
      if (ae >= 64'h80000000 || an >= 64'h80000000) far_enough = 1'b1;
      else far_enough = ae * ae + an * an >= rmin * rmin;
      exp_pt.angle = position_angle(east, north);
      diff = exp_pt.angle - target;
      if (diff > 16'h8000) diff = 16'h0 - diff;
      in_window = diff <= tolerance;
      exp_pt.verdict = spwf_pkg::VERDICT_KEPT;
      if (test_mask[spwf_pkg::MASK_VISIBILITY] && !(seen > 0))
         exp_pt.verdict = spwf_pkg::VERDICT_BEHIND;
      else if (test_mask[spwf_pkg::MASK_RADIUS] && !far_enough)
         exp_pt.verdict = spwf_pkg::VERDICT_TOO_NEAR;
      else if (test_mask[spwf_pkg::MASK_WINDOW] && east == 0 && north == 0)
         exp_pt.verdict = spwf_pkg::VERDICT_ON_AXIS;
      else if (test_mask[spwf_pkg::MASK_WINDOW] && !in_window)
         exp_pt.verdict = spwf_pkg::VERDICT_OUTSIDE;
      exp_pt.x = px;
      exp_pt.y = py;
      exp_pt.z = pz;
      exp_pt.marker = marker;
      pending_q = {pending_q, exp_pt};
   endfunction

   function void check_result(point_verdict_type got);
      point_verdict_type exp_pt;
      if (pending_q.size() == 0) begin
         $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time, got.x, got.y, got.z);
         errors++;
         return;
      end
      exp_pt = pending_q.pop_front();
      if (got.x !== exp_pt.x)
         $display("%0t: out_x expected %0d actual %0d", $time, exp_pt.x, got.x);
      if (got.y !== exp_pt.y)
         $display("%0t: out_y expected %0d actual %0d", $time, exp_pt.y, got.y);
      if (got.z !== exp_pt.z)
         $display("%0t: out_z expected %0d actual %0d", $time, exp_pt.z, got.z);
      if (got.verdict !== exp_pt.verdict)
         $display("%0t: verdict expected %0d actual %0d", $time, exp_pt.verdict, got.verdict);
      if (got.angle !== exp_pt.angle)
         $display("%0t: point_angle expected %0h actual %0h", $time, exp_pt.angle, got.angle);
      if (got.marker !== exp_pt.marker)
         $display("%0t: end_out expected %0b actual %0b", $time, exp_pt.marker, got.marker);
      if (got.x !== exp_pt.x || got.y !== exp_pt.y || got.z !== exp_pt.z ||
          got.verdict !== exp_pt.verdict || got.angle !== exp_pt.angle ||
          got.marker !== exp_pt.marker)
         errors++;
   endfunction
endclass

module tb_sky_plane_point_window_filter;

   typedef logic [spwf_pkg::AXIS_BITS-1:0] axis_word_type;

   localparam int PIPE_LATENCY = 26;
   localparam int STALL_LIMIT  = 4000;
   localparam spwf_pkg::csr_index_type REG_UNUSED = 3'd7;
   localparam logic [17:0] Q_ONE = 18'd65536;

   logic clock, reset;
   logic req_valid, req_stall, req_end_of_cloud;
   logic signed [31:0] req_px, req_py, req_pz;
   logic rsp_valid, rsp_stall, rsp_end_out;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic [spwf_pkg::VERDICT_BITS-1:0] rsp_verdict;
   logic [15:0] rsp_point_angle;
   logic csr_we;
   spwf_pkg::csr_index_type csr_index;
   axis_word_type csr_wdata;

   verdict_board board;
   logic quiet;          // no idling on either side in the closing stretch
   int   stall_left;
   int   idle_cycles;

   sky_plane_point_window_filter uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hold all inputs at known values before the first edge.
   initial begin
      board = new();
      quiet = 1'b0;
      stall_left = 0;
      idle_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_px = '0;
      req_py = '0;
      req_pz = '0;
      req_end_of_cloud = 1'b0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = spwf_pkg::REG_VIEW_AXIS;
      csr_wdata = '0;
   end

   // Receiver: stall in random bursts, none when quiet.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         if (stall_left == 0) rsp_stall <= 1'b0;
      end else if (!reset && !quiet && $urandom_range(0, 9) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(1, 13);
      end
   end

   // Check every result transfer against the oldest prediction.
   always @(posedge clock) begin
      point_verdict_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.x = rsp_out_x;
         got.y = rsp_out_y;
         got.z = rsp_out_z;
         got.verdict = rsp_verdict;
         got.angle = rsp_point_angle;
         got.marker = rsp_end_out;
         board.check_result(got);
      end
   end

   // Watchdog: end the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("sky_plane_point_window_filter: mismatch");
         $finish;
      end
   end

   function automatic axis_word_type pack_axis(logic [17:0] ax, ay, az);
      return {az, ay, ax};
   endfunction

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
         2: return $signed($urandom_range(0, 2 ** 25)) - 2 ** 24;
         3: case ($urandom_range(0, 3))
               0: return 32'sh7FFFFFFF;
               1: return 32'sh80000000;
               2: return 0;
               default: return -1;
            endcase
         default: return $signed($urandom_range(0, 4000)) - 2000;
      endcase
   endfunction

   // Offer one point, with an optional idle burst first; return after transfer.
   task automatic send_point(logic signed [31:0] px, py, pz, logic marker);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_px <= px;
      req_py <= py;
      req_pz <= pz;
      req_end_of_cloud <= marker;
      do @(posedge clock); while (req_stall);
      board.note_point(px, py, pz, marker);
   endtask

   // Drop valid, then wait until every predicted point has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   // Write one register, then idle the port before returning.
   task automatic write_reg(spwf_pkg::csr_index_type idx, axis_word_type data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      board.write_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic random_points(int count);
      for (int i = 0; i < count; i++)
         send_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 7) == 0);
   endtask

   initial begin
      axis_word_type unit_view, unit_east, unit_north;
      unit_view = pack_axis(18'd0, 18'd0, Q_ONE);
      unit_east = pack_axis(Q_ONE, 18'd0, 18'd0);
      unit_north = pack_axis(18'd0, Q_ONE, 18'd0);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: zero view axis puts every point behind the observer.
      send_point(0, 0, 0, 1'b0);
      send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b1);
      send_point(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0);
      drain();

      // Unit basis, window centered on east.
      write_reg(spwf_pkg::REG_VIEW_AXIS, unit_view);
      write_reg(spwf_pkg::REG_EAST_AXIS, unit_east);
      write_reg(spwf_pkg::REG_NORTH_AXIS, unit_north);
      write_reg(spwf_pkg::REG_TARGET, axis_word_type'(16'h4000));
      write_reg(spwf_pkg::REG_TOLERANCE, axis_word_type'(16'h1000));
      write_reg(spwf_pkg::REG_MIN_RADIUS, axis_word_type'(100));
      write_reg(REG_UNUSED, {spwf_pkg::AXIS_BITS{1'b1}});
      send_point(0, 0, 5, 1'b0);                         // on axis, too near
      send_point(1000, 0, -5, 1'b0);                     // behind
      send_point(50, 0, 10, 1'b0);                       // inside min radius
      send_point(1000, 0, 10, 1'b1);                     // kept
      send_point(0, 1000, 10, 1'b0);                     // outside window
      send_point(-1000, -1000, 1, 1'b0);                 // left half-plane
      send_point(32'sh7FFFFFFF, 32'sh80000000, 1, 1'b1); // beyond 2^31 radius
      send_point(-1, 0, 1, 1'b0);
      drain();

      // Mask zero keeps all, then each test alone.
      write_reg(spwf_pkg::REG_TEST_MASK, axis_word_type'(3'b000));
      send_point(0, 0, -5, 1'b0);
      drain();
      write_reg(spwf_pkg::REG_TEST_MASK, axis_word_type'(3'b001));
      send_point(50, 0, 10, 1'b0);
      drain();
      write_reg(spwf_pkg::REG_TEST_MASK, axis_word_type'(3'b010));
      send_point(0, 1000, -10, 1'b0);
      drain();
      write_reg(spwf_pkg::REG_TEST_MASK, axis_word_type'(3'b100));
      write_reg(spwf_pkg::REG_TOLERANCE, axis_word_type'(16'h8000));
      send_point(0, 0, -10, 1'b0);
      send_point(-300, 5, -10, 1'b1);
      drain();
      write_reg(spwf_pkg::REG_TOLERANCE, axis_word_type'(16'hFFFF));
      send_point(-300, -5, 10, 1'b0);
      drain();

      // Random phases over varied settings.
      for (int phase = 0; phase < 8; phase++) begin
         write_reg(spwf_pkg::REG_TEST_MASK,
                   axis_word_type'(phase == 2 ? 3'b000 : spwf_pkg::MASK_RESET));
         if (phase % 3 == 1) begin
            write_reg(spwf_pkg::REG_VIEW_AXIS, axis_word_type'({$urandom, $urandom}));
            write_reg(spwf_pkg::REG_EAST_AXIS, axis_word_type'({$urandom, $urandom}));
            write_reg(spwf_pkg::REG_NORTH_AXIS, axis_word_type'({$urandom, $urandom}));
         end else begin
            write_reg(spwf_pkg::REG_VIEW_AXIS,
                      phase == 4 ? pack_axis(-Q_ONE, 18'd0, 18'd0) : unit_view);
            write_reg(spwf_pkg::REG_EAST_AXIS, unit_east);
            write_reg(spwf_pkg::REG_NORTH_AXIS, unit_north);
         end
         write_reg(spwf_pkg::REG_TARGET, axis_word_type'($urandom));
         write_reg(spwf_pkg::REG_TOLERANCE,
                   axis_word_type'(phase == 5 ? 0 : $urandom_range(0, 16'h8000)));
         case (phase % 4)
            0: write_reg(spwf_pkg::REG_MIN_RADIUS, axis_word_type'(0));
            1: write_reg(spwf_pkg::REG_MIN_RADIUS, axis_word_type'(31'h7FFFFFFF));
            default: write_reg(spwf_pkg::REG_MIN_RADIUS,
                               axis_word_type'($urandom_range(0, 5000)));
         endcase
         if (phase == 7) quiet = 1'b1;
         random_points(25);
         // hold off until the pipeline is empty, then resume mid-phase
         if (phase == 3) begin
            req_valid <= 1'b0;
            while (board.pending_q.size() != 0) @(posedge clock);
         end
         random_points(25);
         drain();
      end

      if (board.errors == 0 && board.pending_q.size() == 0)
         $display("sky_plane_point_window_filter: match");
      else
         $display("sky_plane_point_window_filter: mismatch");
      $finish;
   end

endmodule
